@@ rtl/core/cnlc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnlc_pkg
// Shared types, constants and helpers for the card number Luhn classifier.
// ----------------------------------------------------------------------------
package cnlc_pkg;

  localparam int InBits        = 63;
  // 2^54 > 10^16, so every in-range value fits in 54 bits
  localparam int ValueBits     = 54;
  localparam int DigitCount    = 16;
  localparam int BcdBits       = 4 * DigitCount;
  localparam int StepsPerStage = 6;
  localparam int BcdStages     = ValueBits / StepsPerStage;
  localparam int SumBits       = 8;    // 16 * 9 = 144 at most

  localparam logic [InBits-1:0] LuhnLimit = 63'd10000000000000000;

  typedef enum logic [1:0] {
    BRAND_NONE = 2'd0,
    BRAND_AMEX = 2'd1,
    BRAND_MC   = 2'd2,
    BRAND_VISA = 2'd3
  } brand_t;

  // binary-to-BCD pipeline word
  typedef struct packed {
    logic                 valid;
    logic                 too_large;
    logic [BcdBits-1:0]   bcd;
    logic [ValueBits-1:0] bin;
  } conv_t;

  // Luhn sum stage output
  typedef struct packed {
    logic               valid;
    logic               too_large;
    logic [SumBits-1:0] sum;
    logic [3:0]         digit15;
    logic [3:0]         digit14;
    logic [3:0]         digit13;
    logic [3:0]         digit12;
  } lsum_t;

  // digit sum of 2*d for a decimal digit d
  function automatic logic [3:0] doubled_digit(input logic [3:0] d);
    logic [4:0] p;
    p = {d, 1'b0};
    if (p >= 5'd10) begin
      p = p - 5'd9;
    end
    return p[3:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/cnlc_bcd_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnlc_bcd_stage
// One registered slice of the shift-and-add-3 binary-to-BCD converter.
// ----------------------------------------------------------------------------
module cnlc_bcd_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  cnlc_pkg::conv_t      stage_in,
  output cnlc_pkg::conv_t      stage_out
);

  cnlc_pkg::conv_t                conv_r;
  cnlc_pkg::conv_t                conv_nxt;
  logic [cnlc_pkg::BcdBits-1:0]   bcd_w;
  logic [cnlc_pkg::ValueBits-1:0] bin_w;

  always_comb begin
    bcd_w = stage_in.bcd;
    bin_w = stage_in.bin;
    for (int s = 0; s < cnlc_pkg::StepsPerStage; s++) begin
      for (int d = 0; d < cnlc_pkg::DigitCount; d++) begin
        if (bcd_w[4*d +: 4] >= 4'd5) begin
          bcd_w[4*d +: 4] = bcd_w[4*d +: 4] + 4'd3;
        end
      end
      // top digit overflow only occurs for out-of-range values
      bcd_w = {bcd_w[cnlc_pkg::BcdBits-2:0], bin_w[cnlc_pkg::ValueBits-1]};
      bin_w = {bin_w[cnlc_pkg::ValueBits-2:0], 1'b0};
    end
    conv_nxt           = stage_in;
    conv_nxt.bcd       = bcd_w;
    conv_nxt.bin       = bin_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r.valid <= 1'b0;
    end else begin
      conv_r.valid <= conv_nxt.valid;
    end
    conv_r.too_large <= conv_nxt.too_large;
    conv_r.bcd       <= conv_nxt.bcd;
    conv_r.bin       <= conv_nxt.bin;
  end

  assign stage_out = conv_r;

endmodule
`default_nettype wire

@@ rtl/core/cnlc_luhn_sum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnlc_luhn_sum
// Forms the Luhn digit sum over sixteen BCD digits and keeps leading digits.
// ----------------------------------------------------------------------------
module cnlc_luhn_sum (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  cnlc_pkg::conv_t      conv_in,
  output cnlc_pkg::lsum_t      sum_out
);

  logic [3:0]                   term_w  [cnlc_pkg::DigitCount];
  logic [cnlc_pkg::SumBits-1:0] pair_w  [8];
  logic [cnlc_pkg::SumBits-1:0] quad_w  [4];
  logic [cnlc_pkg::SumBits-1:0] oct_w   [2];
  cnlc_pkg::lsum_t              lsum_r;
  cnlc_pkg::lsum_t              lsum_nxt;

  always_comb begin
    for (int d = 0; d < cnlc_pkg::DigitCount; d++) begin
      // odd positions from the right are doubled
      if (d % 2 == 1) begin
        term_w[d] = cnlc_pkg::doubled_digit(conv_in.bcd[4*d +: 4]);
      end else begin
        term_w[d] = conv_in.bcd[4*d +: 4];
      end
    end
    for (int i = 0; i < 8; i++) begin
      pair_w[i] = {4'd0, term_w[2*i]} + {4'd0, term_w[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      quad_w[i] = pair_w[2*i] + pair_w[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      oct_w[i] = quad_w[2*i] + quad_w[2*i+1];
    end
    lsum_nxt.valid     = conv_in.valid;
    lsum_nxt.too_large = conv_in.too_large;
    lsum_nxt.sum       = oct_w[0] + oct_w[1];
    lsum_nxt.digit15   = conv_in.bcd[60 +: 4];
    lsum_nxt.digit14   = conv_in.bcd[56 +: 4];
    lsum_nxt.digit13   = conv_in.bcd[52 +: 4];
    lsum_nxt.digit12   = conv_in.bcd[48 +: 4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsum_r.valid <= 1'b0;
    end else begin
      lsum_r.valid <= lsum_nxt.valid;
    end
    lsum_r.too_large <= lsum_nxt.too_large;
    lsum_r.sum       <= lsum_nxt.sum;
    lsum_r.digit15   <= lsum_nxt.digit15;
    lsum_r.digit14   <= lsum_nxt.digit14;
    lsum_r.digit13   <= lsum_nxt.digit13;
    lsum_r.digit12   <= lsum_nxt.digit12;
  end

  assign sum_out = lsum_r;

endmodule
`default_nettype wire

@@ rtl/core/cnlc_classify.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnlc_classify
// Mod-10 test on the Luhn sum and brand decode; drives the result register.
// ----------------------------------------------------------------------------
module cnlc_classify (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  cnlc_pkg::lsum_t      sum_in,
  output logic                 res_valid,
  output logic [1:0]           res_brand,
  output logic                 res_luhn_valid
);

  logic             mod_zero_w;
  logic             ok_w;
  cnlc_pkg::brand_t brand_w;
  logic             valid_r;
  cnlc_pkg::brand_t brand_r;
  logic             luhn_r;

  always_comb begin
    // sum is at most 144: match against the multiples of ten
    mod_zero_w = 1'b0;
    for (int k = 0; k <= 14; k++) begin
      if (sum_in.sum == cnlc_pkg::SumBits'(10 * k)) begin
        mod_zero_w = 1'b1;
      end
    end
    ok_w    = mod_zero_w && !sum_in.too_large;
    brand_w = cnlc_pkg::BRAND_NONE;
    if (ok_w) begin
      priority if (sum_in.digit15 == 4'd0 && sum_in.digit14 == 4'd3 &&
                   (sum_in.digit13 == 4'd4 || sum_in.digit13 == 4'd7)) begin
        brand_w = cnlc_pkg::BRAND_AMEX;
      end else if (sum_in.digit15 == 4'd5 && sum_in.digit14 >= 4'd1 &&
                   sum_in.digit14 <= 4'd5) begin
        brand_w = cnlc_pkg::BRAND_MC;
      end else if (sum_in.digit15 == 4'd4 ||
                   (sum_in.digit15 == 4'd0 && sum_in.digit14 == 4'd0 &&
                    sum_in.digit13 == 4'd0 && sum_in.digit12 == 4'd4)) begin
        brand_w = cnlc_pkg::BRAND_VISA;
      end else begin
        brand_w = cnlc_pkg::BRAND_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= sum_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    brand_r <= brand_w;
    luhn_r  <= ok_w;
  end

  assign res_valid      = valid_r;
  assign res_brand      = brand_r;
  assign res_luhn_valid = luhn_r;

endmodule
`default_nettype wire

@@ rtl/core/card_number_luhn_classifier_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_core
// Luhn mod-10 check and brand decode of a binary card number.
// ----------------------------------------------------------------------------
// Each accepted start yields one out_valid at the end of the path below.
// Throughput: one transaction per cycle; busy is always low.
// Path: input register with range compare, nine binary-to-BCD stages of
// six shift steps each, Luhn sum stage, classify/result register.
// Reset (rst_n low, synchronous) clears all valid bits; results not yet
// delivered are dropped. The receiver cannot stall.
module card_number_luhn_classifier_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [62:0] in_card_value,
  output logic             out_valid,
  output logic [1:0]       out_brand,
  output logic             out_luhn_valid
);

  cnlc_pkg::conv_t entry_r;
  cnlc_pkg::conv_t entry_nxt;
  cnlc_pkg::conv_t conv_w [cnlc_pkg::BcdStages+1];
  cnlc_pkg::lsum_t lsum_w;

  assign busy = 1'b0;

  always_comb begin
    entry_nxt.valid     = start && !busy;
    entry_nxt.too_large = (in_card_value >= cnlc_pkg::LuhnLimit);
    entry_nxt.bcd       = '0;
    entry_nxt.bin       = in_card_value[cnlc_pkg::ValueBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.too_large <= entry_nxt.too_large;
    entry_r.bcd       <= entry_nxt.bcd;
    entry_r.bin       <= entry_nxt.bin;
  end

  assign conv_w[0] = entry_r;

  for (genvar g = 0; g < cnlc_pkg::BcdStages; g++) begin : g_bcd
    cnlc_bcd_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (conv_w[g]),
      .stage_out (conv_w[g+1])
    );
  end

  cnlc_luhn_sum u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .conv_in (conv_w[cnlc_pkg::BcdStages]),
    .sum_out (lsum_w)
  );

  cnlc_classify u_classify (
    .clk            (clk),
    .rst_n          (rst_n),
    .sum_in         (lsum_w),
    .res_valid      (out_valid),
    .res_brand      (out_brand),
    .res_luhn_valid (out_luhn_valid)
  );

endmodule
`default_nettype wire
